// ===== rtl/slf_pkg.sv =====
`default_nettype none

package slf_pkg;

	// Counter width of the sonar cycle and the chained divider
	localparam int COUNT_BITS = 13;
	localparam int POLL_BITS  = 9;
	localparam int SCALE_BITS = 16;
	localparam int RANGE_BITS = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [RANGE_BITS-1:0] RANGE_MAX   = RANGE_BITS'(4095);
	localparam logic [RANGE_BITS-1:0] RANGE_RESET = RANGE_BITS'(4000);

	// Drive byte bits
	localparam logic [7:0] TRIG = 8'h01;
	localparam logic [7:0] RFWD = 8'h08;
	localparam logic [7:0] RBCK = 8'h10;
	localparam logic [7:0] LFWD = 8'h20;
	localparam logic [7:0] LBCK = 8'h40;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SONAR_PERIOD  = 3'd0,
		REG_POLL_PERIOD   = 3'd1,
		REG_ECHO_OFFSET   = 3'd2,
		REG_RANGE_SCALE   = 3'd3,
		REG_STOP_DISTANCE = 3'd4,
		REG_CHAIN_BASE    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] sonar_period;
		logic [POLL_BITS-1:0]  poll_period;
		logic [COUNT_BITS-1:0] echo_offset;
		logic [SCALE_BITS-1:0] range_scale;
		logic [RANGE_BITS-1:0] stop_distance;
		logic [COUNT_BITS-1:0] chain_base;
	} cfg_t;

	typedef struct packed {
		logic func;
		logic line_left;
		logic line_mid;
		logic line_right;
	} item_t;

	typedef struct packed {
		logic [7:0]            drive_byte;
		logic                  port_write;
		logic                  chain_pulse;
		logic [RANGE_BITS-1:0] range_cm;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/sonar_line_follower_controller.sv =====
// Line follower controller with ultrasonic stop.
// Input channel (in_valid / in_stall): one item per transfer, func = 0 is a
// timer tick, func = 1 an echo-end event; line_left/mid/right are the line
// sensor levels sampled with the item.
// Output channel (out_valid / out_stall): exactly one result per item, in
// order: drive_byte (trigger and motor bits), port_write, chain_pulse and
// the current range_cm.
// Configuration: cfg_we writes cfg_data into the register picked by
// cfg_index; write only while no item is in flight.
// Path: the transfer loads the input register, and the update logic then
// passes into the result register once stage 2 can advance. Throughput: one
// item per cycle while no result is held by out_stall; the single pass holds
// the multiplier of the echo range conversion.
// Reset (arst_n low) clears both pipeline stages, the counters and the
// drive byte, sets range to 4000 and reloads the default configuration.
// When out_stall is high the result holds; the input register still takes
// one item, after which in_stall rises until the result is taken.
`default_nettype none

module sonar_line_follower_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            func,
	input  wire logic                            line_left,
	input  wire logic                            line_mid,
	input  wire logic                            line_right,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           drive_byte,
	output logic                                 port_write,
	output logic                                 chain_pulse,
	output logic [slf_pkg::RANGE_BITS-1:0]       range_cm,
	input  wire logic                            cfg_we,
	input  wire logic [slf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [slf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import slf_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    v_s1;
	result_t res_next;
	result_t res_s2;
	logic    v_s2;
	logic    advance;
	logic    take_in;

	slf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 2 moves when empty or being taken
	assign advance  = !v_s2 || !out_stall;
	assign in_stall = v_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.func       <= func;
			item_s1.line_left  <= line_left;
			item_s1.line_mid   <= line_mid;
			item_s1.line_right <= line_right;
		end
	end

	slf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (v_s1 && advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid   = v_s2;
	assign drive_byte  = res_s2.drive_byte;
	assign port_write  = res_s2.port_write;
	assign chain_pulse = res_s2.chain_pulse;
	assign range_cm    = res_s2.range_cm;

endmodule

`default_nettype wire

// ===== rtl/slf_cfg_regs.sv =====
`default_nettype none

module slf_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [slf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [slf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output slf_pkg::cfg_t                        cfg
);
	import slf_pkg::*;

	cfg_t cfg_q;

	// Register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sonar_period  <= COUNT_BITS'(5966);
			cfg_q.poll_period   <= POLL_BITS'(497);
			cfg_q.echo_offset   <= COUNT_BITS'(49);
			cfg_q.range_scale   <= SCALE_BITS'(11364);
			cfg_q.stop_distance <= RANGE_BITS'(20);
			cfg_q.chain_base    <= COUNT_BITS'(5461);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SONAR_PERIOD:  cfg_q.sonar_period  <= cfg_data[COUNT_BITS-1:0];
				REG_POLL_PERIOD:   cfg_q.poll_period   <= cfg_data[POLL_BITS-1:0];
				REG_ECHO_OFFSET:   cfg_q.echo_offset   <= cfg_data[COUNT_BITS-1:0];
				REG_RANGE_SCALE:   cfg_q.range_scale   <= cfg_data[SCALE_BITS-1:0];
				REG_STOP_DISTANCE: cfg_q.stop_distance <= cfg_data[RANGE_BITS-1:0];
				REG_CHAIN_BASE:    cfg_q.chain_base    <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/slf_core.sv =====
`default_nettype none

module slf_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  slf_pkg::item_t   item,
	input  slf_pkg::cfg_t    cfg,
	output slf_pkg::result_t res
);
	import slf_pkg::*;

	localparam int PROD_W = COUNT_BITS + SCALE_BITS;
	localparam int CMP_W  = (COUNT_BITS > RANGE_BITS) ? COUNT_BITS : RANGE_BITS;

	logic [7:0]            out_byte_q;
	logic [COUNT_BITS-1:0] cycle_count_q;
	logic [POLL_BITS-1:0]  poll_count_q;
	logic [RANGE_BITS-1:0] range_q;
	logic [COUNT_BITS-1:0] chain_count_q;
	logic [1:0]            chain_phase_q;

	logic [7:0]            byte_d;
	logic [COUNT_BITS-1:0] cycle_d;
	logic [POLL_BITS-1:0]  poll_d;
	logic [RANGE_BITS-1:0] range_d;
	logic [COUNT_BITS-1:0] chain_count_d;
	logic [1:0]            chain_phase_d;
	logic                  pw;
	logic                  pulse;

	// Echo range: (count - offset) * scale in Q16, saturated
	logic [COUNT_BITS-1:0] diff;
	logic [PROD_W-1:0]     prod;
	logic [CMP_W-1:0]      quot;
	assign diff = cycle_count_q - cfg.echo_offset;
	assign prod = PROD_W'(diff) * PROD_W'(cfg.range_scale);
	assign quot = CMP_W'(prod[PROD_W-1:SCALE_BITS]);

	// Next state and result for one item
	always_comb begin
		logic                  chain_end;
		logic [COUNT_BITS:0]   chain_inc;
		logic [COUNT_BITS:0]   sonar_inc;
		logic [POLL_BITS:0]    poll_inc;
		logic [7:0]            b1;
		logic [7:0]            b2;

		byte_d        = out_byte_q;
		cycle_d       = cycle_count_q;
		poll_d        = poll_count_q;
		range_d       = range_q;
		chain_count_d = chain_count_q;
		chain_phase_d = chain_phase_q;
		pw            = 1'b0;
		pulse         = 1'b0;
		chain_inc     = {1'b0, chain_count_q} + 1'b1;
		sonar_inc     = {1'b0, cycle_count_q} + 1'b1;
		poll_inc      = {1'b0, poll_count_q} + 1'b1;
		chain_end     = 1'b0;
		b1            = out_byte_q;
		b2            = out_byte_q;

		if (item.func) begin
			if (cycle_count_q < cfg.echo_offset)
				range_d = RANGE_MAX;
			else if (quot > CMP_W'(RANGE_MAX))
				range_d = RANGE_MAX;
			else
				range_d = quot[RANGE_BITS-1:0];
		end else begin
			// fractional divider: long period first, then two short ones
			if (chain_phase_q == 2'd0)
				chain_end = (chain_count_q >= cfg.chain_base);
			else
				chain_end = (chain_inc >= {1'b0, cfg.chain_base});
			if (chain_end) begin
				chain_phase_d = (chain_phase_q >= 2'd2) ? 2'd0 : chain_phase_q + 2'd1;
				chain_count_d = '0;
				pulse         = 1'b1;
			end else begin
				chain_count_d = chain_inc[COUNT_BITS-1:0];
			end

			// sonar trigger pulse
			if (cycle_count_q == COUNT_BITS'(0)) begin
				b1 = out_byte_q | TRIG;
				pw = 1'b1;
			end else if (cycle_count_q == COUNT_BITS'(1)) begin
				b1 = out_byte_q & ~TRIG;
				pw = 1'b1;
			end
			b2 = b1;

			// steering on poll
			if (poll_count_q == POLL_BITS'(0)) begin
				if (range_q < cfg.stop_distance)
					b2 = b1 & ~(RFWD | RBCK | LFWD | LBCK);
				else if (item.line_left ^ item.line_right) begin
					if (item.line_mid) begin
						if (item.line_left) b2 = (b1 & ~(RFWD | LBCK)) | (LFWD | RBCK);
						else                b2 = (b1 & ~(LFWD | RBCK)) | (RFWD | LBCK);
					end else begin
						if (item.line_left) b2 = (b1 & ~(RFWD | LBCK | RBCK)) | LFWD;
						else                b2 = (b1 & ~(LFWD | LBCK | RBCK)) | RFWD;
					end
				end else if (!item.line_mid && !item.line_left)
					b2 = (b1 & ~(LBCK | RBCK)) | (LFWD | RFWD);
				if (b2 != b1) pw = 1'b1;
			end
			byte_d = b2;

			cycle_d = (sonar_inc >= {1'b0, cfg.sonar_period}) ? '0
			        : sonar_inc[COUNT_BITS-1:0];
			poll_d  = (poll_inc >= {1'b0, cfg.poll_period}) ? '0
			        : poll_inc[POLL_BITS-1:0];
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_byte_q    <= '0;
			cycle_count_q <= '0;
			poll_count_q  <= '0;
			range_q       <= RANGE_RESET;
			chain_count_q <= '0;
			chain_phase_q <= '0;
		end else if (en) begin
			out_byte_q    <= byte_d;
			cycle_count_q <= cycle_d;
			poll_count_q  <= poll_d;
			range_q       <= range_d;
			chain_count_q <= chain_count_d;
			chain_phase_q <= chain_phase_d;
		end
	end

	assign res.drive_byte  = byte_d;
	assign res.port_write  = pw;
	assign res.chain_pulse = pulse;
	assign res.range_cm    = range_d;

endmodule

`default_nettype wire

// ===== rtl/slf_checker.sv =====
`default_nettype none

module slf_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [7:0]                      drive_byte,
	input wire logic                            port_write,
	input wire logic                            chain_pulse,
	input wire logic [slf_pkg::RANGE_BITS-1:0]  range_cm
);

	// Input backpressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// A held result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(drive_byte) &&
			$stable(port_write) && $stable(chain_pulse) && $stable(range_cm)))
		else $error("held result changed");

	// Unused drive bits never set
	a_byte_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_byte[7] == 1'b0 && drive_byte[2:1] == 2'b00))
		else $error("unused drive byte bit set");

	// No result right after reset release
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind sonar_line_follower_controller slf_checker u_slf_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slf_pkg::*;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ECHO = 1'b1;
	// Index past the register file: the write must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_GAP    = 4;
	localparam int HOLD_LEN     = 150;
	localparam int PHASE_ITEMS  = 230;
	localparam int LONG_ITEMS   = 300;
	localparam int REPORT_MAX   = 10;
	localparam int DIR_N        = 32;

	typedef struct {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		item_t                 it;
		logic                  typed;
		result_t               want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic line_left = 1'b0;
	logic line_mid = 1'b0;
	logic line_right = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] drive_byte;
	logic port_write;
	logic chain_pulse;
	logic [RANGE_BITS-1:0] range_cm;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Controller state as the predictor sees it
	cfg_t regs;
	logic [7:0] drv_q;
	logic [COUNT_BITS-1:0] sonar_cnt;
	logic [POLL_BITS-1:0] poll_cnt;
	logic [RANGE_BITS-1:0] range_q;
	logic [COUNT_BITS-1:0] chain_cnt;
	logic [1:0] chain_phase;

	result_t queued_outputs[$];
	result_t head;
	int mismatches = 0;
	int unsigned cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_start = 1'b0;
	int hold_left = 0;
	stim_row_t directed_rows [DIR_N];

	sonar_line_follower_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.line_left(line_left),
		.line_mid(line_mid),
		.line_right(line_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_byte(drive_byte),
		.port_write(port_write),
		.chain_pulse(chain_pulse),
		.range_cm(range_cm),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predict one result and advance the state by one item
	function automatic result_t advance_controller(input item_t it);
		result_t res;
		logic [7:0] prior;
		logic [28:0] span;
		logic period_end;
		res = '0;
		if (it.func == OP_ECHO) begin
			// echo: convert cycle count to distance, clamp, count below offset reads max
			if (sonar_cnt < regs.echo_offset) begin
				range_q = RANGE_MAX;
			end else begin
				span = (29'(sonar_cnt) - 29'(regs.echo_offset)) * 29'(regs.range_scale);
				span = span >> SCALE_BITS;
				range_q = (span > 29'(RANGE_MAX)) ? RANGE_MAX : span[RANGE_BITS-1:0];
			end
		end else begin
			// fractional divider: first period is one tick longer
			period_end = (chain_phase == 2'd0) ? (chain_cnt >= regs.chain_base)
				: ((14'(chain_cnt) + 14'd1) >= 14'(regs.chain_base));
			if (period_end) begin
				chain_phase = (chain_phase >= 2'd2) ? 2'd0 : chain_phase + 2'd1;
				chain_cnt = '0;
				res.chain_pulse = 1'b1;
			end else begin
				chain_cnt = chain_cnt + 1'b1;
			end
			// sonar trigger pulse
			if (sonar_cnt == 0) begin
				drv_q = drv_q | TRIG;
				res.port_write = 1'b1;
			end else if (sonar_cnt == 1) begin
				drv_q = drv_q & ~TRIG;
				res.port_write = 1'b1;
			end
			// steering on poll
			if (poll_cnt == 0) begin
				prior = drv_q;
				if (range_q < regs.stop_distance) begin
					drv_q = drv_q & ~(RFWD | RBCK | LFWD | LBCK);
				end else if (it.line_left ^ it.line_right) begin
					if (it.line_mid) begin
						drv_q = it.line_left ? ((drv_q & ~(RFWD | LBCK)) | LFWD | RBCK)
							: ((drv_q & ~(LFWD | RBCK)) | RFWD | LBCK);
					end else begin
						drv_q = it.line_left ? ((drv_q & ~(RFWD | LBCK | RBCK)) | LFWD)
							: ((drv_q & ~(LFWD | LBCK | RBCK)) | RFWD);
					end
				end else if (!it.line_mid && !it.line_left) begin
					drv_q = (drv_q & ~(LBCK | RBCK)) | LFWD | RFWD;
				end
				if (prior != drv_q)
					res.port_write = 1'b1;
			end
			sonar_cnt = ((14'(sonar_cnt) + 14'd1) >= 14'(regs.sonar_period)) ? '0
				: sonar_cnt + 1'b1;
			poll_cnt = ((10'(poll_cnt) + 10'd1) >= 10'(regs.poll_period)) ? '0
				: poll_cnt + 1'b1;
		end
		res.drive_byte = drv_q;
		res.range_cm = range_q;
		return res;
	endfunction

	function automatic stim_row_t item_row(input logic f, l, m, r);
		stim_row_t row;
		row = '{is_cfg: 1'b0, idx: '0, val: '0, it: '{f, l, m, r}, typed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic stim_row_t typed_row(input logic f, l, m, r, input result_t want);
		stim_row_t row;
		row = item_row(f, l, m, r);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t row;
		row = '{is_cfg: 1'b1, idx: idx, val: val, it: '0, typed: 1'b0, want: '0};
		return row;
	endfunction

	// Random upper bits above the register width; the block must drop them
	function automatic logic [CFG_DATA_W-1:0] pad_bits(input int unsigned val, input int w);
		logic [CFG_DATA_W-1:0] upper;
		upper = (w >= CFG_DATA_W) ? '0 : CFG_DATA_W'($urandom) << w;
		return upper | CFG_DATA_W'(val);
	endfunction

	function automatic item_t rand_item(input int echo_pct);
		item_t it;
		it.func = ($urandom_range(99) < echo_pct) ? OP_ECHO : OP_TICK;
		it.line_left = 1'($urandom_range(1));
		it.line_mid = 1'($urandom_range(1));
		it.line_right = 1'($urandom_range(1));
		return it;
	endfunction

	// Offer one item, hold it until the transfer, queue its prediction
	task automatic send_item(input item_t it, input logic typed, input result_t want);
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		line_left <= it.line_left;
		line_mid <= it.line_mid;
		line_right <= it.line_right;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = advance_controller(it);
		queued_outputs.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Stop offering and wait until every queued result is out
	task automatic settle();
		in_valid <= 1'b0;
		while (queued_outputs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SONAR_PERIOD:  regs.sonar_period = val[COUNT_BITS-1:0];
			REG_POLL_PERIOD:   regs.poll_period = val[POLL_BITS-1:0];
			REG_ECHO_OFFSET:   regs.echo_offset = val[COUNT_BITS-1:0];
			REG_RANGE_SCALE:   regs.range_scale = val[SCALE_BITS-1:0];
			REG_STOP_DISTANCE: regs.stop_distance = val[RANGE_BITS-1:0];
			REG_CHAIN_BASE:    regs.chain_base = val[COUNT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// New setting per phase; about one register in four lands on an extreme
	task automatic randomize_settings();
		write_reg(REG_SONAR_PERIOD, pad_bits(($urandom_range(3) == 0)
			? ($urandom_range(1) ? 8191 : $urandom_range(1)) : $urandom_range(2, 300), COUNT_BITS));
		write_reg(REG_POLL_PERIOD, pad_bits(($urandom_range(3) == 0)
			? ($urandom_range(1) ? 511 : 0) : $urandom_range(1, 6), POLL_BITS));
		write_reg(REG_ECHO_OFFSET, pad_bits(($urandom_range(3) == 0)
			? ($urandom_range(1) ? 8191 : 0) : $urandom_range(0, 60), COUNT_BITS));
		write_reg(REG_RANGE_SCALE, pad_bits(($urandom_range(3) == 0)
			? ($urandom_range(1) ? 65535 : 0) : $urandom_range(65535), SCALE_BITS));
		write_reg(REG_STOP_DISTANCE, pad_bits(($urandom_range(3) == 0)
			? ($urandom_range(1) ? 4095 : 0) : $urandom_range(0, 150), RANGE_BITS));
		write_reg(REG_CHAIN_BASE, pad_bits(($urandom_range(3) == 0)
			? ($urandom_range(1) ? 8191 : 0) : $urandom_range(1, 40), COUNT_BITS));
	endtask

	task automatic run_random(input int count, input int echo_pct);
		for (int i = 0; i < count; i++) begin
			// long output hold-off while items keep coming
			if (i == 100)
				hold_start = 1'b1;
			send_item(rand_item(echo_pct), 1'b0, '0);
		end
	endtask

	// Receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_LEN;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (queued_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: drive %02h pw %0d pulse %0d range %0d",
						drive_byte, port_write, chain_pulse, range_cm);
			end else begin
				head = queued_outputs.pop_front();
				if (drive_byte !== head.drive_byte || port_write !== head.port_write ||
						chain_pulse !== head.chain_pulse || range_cm !== head.range_cm) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: expected drive %02h pw %0d pulse %0d range %0d, got drive %02h pw %0d pulse %0d range %0d",
							head.drive_byte, head.port_write, head.chain_pulse, head.range_cm,
							drive_byte, port_write, chain_pulse, range_cm);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		regs.sonar_period = 13'd5966;
		regs.poll_period = 9'd497;
		regs.echo_offset = 13'd49;
		regs.range_scale = 16'd11364;
		regs.stop_distance = 12'd20;
		regs.chain_base = 13'd5461;
		drv_q = '0;
		sonar_cnt = '0;
		poll_cnt = '0;
		range_q = RANGE_RESET;
		chain_cnt = '0;
		chain_phase = '0;

		// Directed rows: results typed in where they follow straight from reset
		directed_rows = '{
			typed_row(OP_TICK, 1'b0, 1'b0, 1'b0, {TRIG | LFWD | RFWD, 1'b1, 1'b0, RANGE_RESET}),
			typed_row(OP_TICK, 1'b0, 1'b0, 1'b0, {LFWD | RFWD, 1'b1, 1'b0, RANGE_RESET}),
			typed_row(OP_TICK, 1'b1, 1'b1, 1'b1, {LFWD | RFWD, 1'b0, 1'b0, RANGE_RESET}),
			// echo with count under the offset reads maximum range
			typed_row(OP_ECHO, 1'b1, 1'b1, 1'b1, {LFWD | RFWD, 1'b0, 1'b0, RANGE_MAX}),
			// zero periods: poll restarts at once, divider ends every tick
			cfg_row(REG_POLL_PERIOD, '0),
			cfg_row(REG_CHAIN_BASE, '0),
			item_row(OP_TICK, 1'b1, 1'b0, 1'b0),
			item_row(OP_TICK, 1'b1, 1'b0, 1'b0),
			item_row(OP_TICK, 1'b1, 1'b1, 1'b0),
			item_row(OP_TICK, 1'b0, 1'b1, 1'b1),
			item_row(OP_TICK, 1'b0, 1'b0, 1'b1),
			item_row(OP_TICK, 1'b1, 1'b0, 1'b1),
			item_row(OP_TICK, 1'b0, 1'b1, 1'b0),
			item_row(OP_TICK, 1'b0, 1'b0, 1'b0),
			// short range below the stop distance
			cfg_row(REG_ECHO_OFFSET, '0),
			cfg_row(REG_RANGE_SCALE, 16'hFFFF),
			cfg_row(REG_CHAIN_BASE, 16'd2),
			item_row(OP_ECHO, 1'b0, 1'b0, 1'b0),
			item_row(OP_TICK, 1'b1, 1'b1, 1'b0),
			item_row(OP_TICK, 1'b0, 1'b0, 1'b0),
			// sonar period under the current count wraps at once
			cfg_row(REG_STOP_DISTANCE, '0),
			cfg_row(REG_SONAR_PERIOD, 16'd1),
			item_row(OP_TICK, 1'b0, 1'b0, 1'b0),
			item_row(OP_TICK, 1'b0, 1'b0, 1'b0),
			item_row(OP_TICK, 1'b1, 1'b1, 1'b1),
			cfg_row(REG_ECHO_OFFSET, 16'hFFFF),
			item_row(OP_ECHO, 1'b1, 1'b1, 1'b1),
			cfg_row(REG_NONE, 16'hFFFF),
			cfg_row(REG_SONAR_PERIOD, 16'hFFFF),
			item_row(OP_TICK, 1'b1, 1'b1, 1'b1),
			item_row(OP_TICK, 1'b0, 1'b0, 1'b0),
			item_row(OP_ECHO, 1'b0, 1'b0, 1'b0)
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 87;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases under each idle pattern, two settings apiece
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 87 : 0;
			recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 30 : 0;
			for (int s = 0; s < 2; s++) begin
				settle();
				randomize_settings();
				run_random(PHASE_ITEMS, 12);
			end
		end

		// Long sonar cycle at full range scale, rare echoes
		settle();
		write_reg(REG_SONAR_PERIOD, 16'd8191);
		write_reg(REG_POLL_PERIOD, 16'd2);
		write_reg(REG_ECHO_OFFSET, 16'd0);
		write_reg(REG_RANGE_SCALE, 16'hFFFF);
		write_reg(REG_STOP_DISTANCE, 16'd4095);
		write_reg(REG_CHAIN_BASE, 16'd1000);
		run_random(LONG_ITEMS, 1);

		settle();
		repeat (2 * DRAIN_GAP) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
